### rtl/dlef_pkg.sv
// Shared types, codes and the CRC-8 helper for the DLE framer.
package dlef_pkg;

    localparam logic [7:0] DLE = 8'h10;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] ETX = 8'h03;
    localparam logic [7:0] CRC_POLY = 8'b0000_0111;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;
    localparam logic [7:0] PACKET_TYPE_RESET = 8'd0;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_ROOM     = 2'd1,
        ST_NO_ROOM_DLE = 2'd2
    } status_t;

    typedef enum logic {
        CFG_MAX_LENGTH  = 1'b0,
        CFG_PACKET_TYPE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        status_t    status;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic take;
        logic idle;
    } seq_ctrl_t;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        logic       inv;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            inv = b[i] ^ c[7];
            c = {c[6:0], 1'b0};
            if (inv)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

### rtl/dlef_if.sv
// Valid/ready channels for payload bytes in and framed bytes out.
interface dlef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output final_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input final_byte, output ready);
endinterface

interface dlef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output out_byte, output status,
                    output run_last, input ready);
    modport sink (input valid, input out_byte, input status,
                  input run_last, output ready);
endinterface

### rtl/dle_framer_with_crc8.sv
// Top level of the DLE/STX/ETX byte-stuffing framer with CRC-8.
// Path: an accepted request is held in the input register until the sequencer
// takes it; the sequencer emits one output byte per slot into the output register.
// Throughput: one output byte per cycle while the output register has room; the
// sequencer works on one request at a time (a stuffed DLE adds an output byte).
// Reset: max_length to 255, packet_type to 0, CRC, count and frame flags cleared.
module dle_framer_with_crc8 (
    input  logic       clk,
    input  logic       rst_n,
    dlef_in_if.sink    payload,
    dlef_out_if.source frame,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] max_length_reg, max_length_next;
    logic [7:0] packet_type_reg, packet_type_next;

    logic            in_valid_reg, in_valid_next;
    dlef_pkg::item_t in_item_reg;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg;
    dlef_pkg::status_t   status_reg;
    logic                run_last_reg;

    dlef_pkg::seq_ctrl_t seq_ctrl;
    dlef_pkg::result_t   seq_res;
    logic                out_room;
    logic                in_accept;

    always_comb
    begin
        max_length_next  = max_length_reg;
        packet_type_next = packet_type_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dlef_pkg::CFG_MAX_LENGTH:  max_length_next = cfg_wdata;
                dlef_pkg::CFG_PACKET_TYPE: packet_type_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign payload.ready = !in_valid_reg || seq_ctrl.take;
    assign in_accept     = payload.valid && payload.ready;
    assign in_valid_next = in_accept ? 1'b1 : (seq_ctrl.take ? 1'b0 : in_valid_reg);

    assign out_room       = !out_valid_reg || frame.ready;
    assign out_valid_next = out_room ? seq_res.valid : out_valid_reg;

    dlef_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (in_item_reg),
        .item_valid  (in_valid_reg),
        .res_ready   (out_room),
        .max_length  (max_length_reg),
        .packet_type (packet_type_reg),
        .ctrl        (seq_ctrl),
        .res         (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg  <= dlef_pkg::MAX_LENGTH_RESET;
            packet_type_reg <= dlef_pkg::PACKET_TYPE_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_length_reg  <= max_length_next;
            packet_type_reg <= packet_type_next;
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.data_byte  <= payload.data_byte;
            in_item_reg.first_byte <= payload.first_byte;
            in_item_reg.final_byte <= payload.final_byte;
        end
        if (out_room && seq_res.valid)
        begin
            out_byte_reg <= seq_res.out_byte;
            status_reg   <= seq_res.status;
            run_last_reg <= seq_res.run_last;
        end
    end

    assign frame.valid    = out_valid_reg;
    assign frame.out_byte = out_byte_reg;
    assign frame.status   = status_reg;
    assign frame.run_last = run_last_reg;

    // an error result always closes its request and carries no byte
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && (status_reg != dlef_pkg::ST_OK))
            |-> (run_last_reg && (out_byte_reg == 8'd0)))
        else $error("error result not last or byte not zero");

    // an idle sequencer never leaves a held request waiting
    a_idle_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && seq_ctrl.idle) |-> seq_ctrl.take)
        else $error("idle sequencer did not take held request");

    // a sequencer result is only produced when the output register has room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        seq_res.valid |-> out_room)
        else $error("result produced with output register full");

endmodule

### rtl/dlef_seq.sv
// Frame sequencer: walks the byte slots of one request, one output byte a cycle while res_ready is high.
module dlef_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  dlef_pkg::item_t    item,
    input  logic               item_valid,
    input  logic               res_ready,
    input  logic [7:0]         max_length,
    input  logic [7:0]         packet_type,
    output dlef_pkg::seq_ctrl_t ctrl,
    output dlef_pkg::result_t  res
);

    typedef enum logic [7:0] {
        SL_IDLE = 8'b0000_0001,
        SL_DLE0 = 8'b0000_0010,
        SL_STX  = 8'b0000_0100,
        SL_TYPE = 8'b0000_1000,
        SL_DATA = 8'b0001_0000,
        SL_CRC  = 8'b0010_0000,
        SL_DLE1 = 8'b0100_0000,
        SL_ETX  = 8'b1000_0000
    } slot_t;

    slot_t      slot_reg, slot_next;
    logic       dup_reg, dup_next;
    logic       in_frame_reg, in_frame_next;
    logic       dropping_reg, dropping_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] data_reg, data_next;
    logic       fin_reg, fin_next;

    logic [7:0] cur_byte;
    logic       use_crc;
    logic       stuff;
    slot_t      after_slot;
    logic       emit;
    logic       room;
    logic       fail;
    logic       finish;
    logic       take;

    always_comb
    begin
        case (slot_reg)
            SL_DLE0: cur_byte = dlef_pkg::DLE;
            SL_STX:  cur_byte = dlef_pkg::STX;
            SL_TYPE: cur_byte = packet_type;
            SL_DATA: cur_byte = data_reg;
            SL_CRC:  cur_byte = crc_reg;
            SL_DLE1: cur_byte = dlef_pkg::DLE;
            SL_ETX:  cur_byte = dlef_pkg::ETX;
            default: cur_byte = 8'd0;
        endcase

        case (slot_reg)
            SL_DLE0: after_slot = SL_STX;
            SL_STX:  after_slot = SL_TYPE;
            SL_TYPE: after_slot = SL_DATA;
            SL_DATA: after_slot = fin_reg ? SL_CRC : SL_IDLE;
            SL_CRC:  after_slot = SL_DLE1;
            SL_DLE1: after_slot = SL_ETX;
            default: after_slot = SL_IDLE;
        endcase
    end

    assign use_crc = (slot_reg == SL_TYPE) || (slot_reg == SL_DATA);
    assign stuff   = use_crc || (slot_reg == SL_CRC);
    assign room    = count_reg < max_length;
    assign emit    = (slot_reg != SL_IDLE) && res_ready;

    always_comb
    begin
        slot_next     = slot_reg;
        dup_next      = dup_reg;
        in_frame_next = in_frame_reg;
        dropping_next = dropping_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        data_next     = data_reg;
        fin_next      = fin_reg;
        res.valid     = 1'b0;
        res.out_byte  = 8'd0;
        res.status    = dlef_pkg::ST_OK;
        res.run_last  = 1'b0;
        fail          = 1'b0;

        if (emit)
        begin
            res.valid = 1'b1;
            if (!room)
            begin
                fail       = 1'b1;
                res.status = dup_reg ? dlef_pkg::ST_NO_ROOM_DLE : dlef_pkg::ST_NO_ROOM;
            end
            else if (dup_reg)
            begin
                res.out_byte = dlef_pkg::DLE;
                count_next   = count_reg + 8'd1;
                dup_next     = 1'b0;
                slot_next    = after_slot;
                res.run_last = (after_slot == SL_IDLE);
            end
            else
            begin
                res.out_byte = cur_byte;
                count_next   = count_reg + 8'd1;
                if (use_crc)
                begin
                    crc_next = dlef_pkg::crc8_feed(crc_reg, cur_byte);
                end
                if (stuff && (cur_byte == dlef_pkg::DLE))
                begin
                    dup_next = 1'b1;
                end
                else
                begin
                    slot_next    = after_slot;
                    res.run_last = (after_slot == SL_IDLE);
                    // closing ETX ends the frame
                    if (slot_reg == SL_ETX)
                    begin
                        in_frame_next = 1'b0;
                    end
                end
            end

            if (fail)
            begin
                slot_next     = SL_IDLE;
                dup_next      = 1'b0;
                in_frame_next = 1'b0;
                dropping_next = 1'b1;
                res.run_last  = 1'b1;
            end
        end

        finish = emit && res.run_last;
        take   = item_valid && ((slot_reg == SL_IDLE) || finish);

        // next request sees the frame state left by the one finishing now
        if (take)
        begin
            data_next = item.data_byte;
            fin_next  = item.final_byte;
            if (item.first_byte)
            begin
                crc_next      = 8'd0;
                count_next    = 8'd0;
                in_frame_next = 1'b1;
                dropping_next = 1'b0;
                dup_next      = 1'b0;
                slot_next     = SL_DLE0;
            end
            else if (in_frame_next && !dropping_next)
            begin
                slot_next = SL_DATA;
            end
        end
    end

    assign ctrl.take = take;
    assign ctrl.idle = (slot_reg == SL_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= SL_IDLE;
            dup_reg      <= 1'b0;
            in_frame_reg <= 1'b0;
            dropping_reg <= 1'b0;
            crc_reg      <= 8'd0;
            count_reg    <= 8'd0;
        end
        else
        begin
            slot_reg     <= slot_next;
            dup_reg      <= dup_next;
            in_frame_reg <= in_frame_next;
            dropping_reg <= dropping_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        fin_reg  <= fin_next;
    end

endmodule

### tb/sv/tb_dle_framer_with_crc8.sv
// Testbench for the DLE/STX/ETX framer: random framed traffic against a CRC-8 predictor.
`timescale 1ns / 100ps

module tb_dle_framer_with_crc8;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS = 54;

    typedef struct packed {
        logic [7:0]        out_byte;
        dlef_pkg::status_t status;
        logic              run_last;
    } frame_byte_t;

    // Predicts the framed byte stream and checks what the block sends.
    class frame_scoreboard;
        logic [7:0]  max_length;
        logic [7:0]  packet_type;
        logic [7:0]  crc;
        logic [7:0]  sent;
        bit          open_frame;
        bit          dropping;
        bit          overflowed;
        frame_byte_t pending[$];
        frame_byte_t item_bytes[$];
        int unsigned errors;
        int unsigned item_count;

        function new();
            max_length = dlef_pkg::MAX_LENGTH_RESET;
            packet_type = dlef_pkg::PACKET_TYPE_RESET;
            crc = 8'h00;
            sent = 8'h00;
            open_frame = 1'b0;
            dropping = 1'b0;
            errors = 0;
            item_count = 0;
        endfunction

        function void set_reg(dlef_pkg::cfg_index_t idx, logic [7:0] value);
            if (idx == dlef_pkg::CFG_MAX_LENGTH)
            begin
                max_length = value;
            end
            else
            begin
                packet_type = value;
            end
        endfunction

        function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = b[i] ^ r[7];
                r = {r[6:0], 1'b0};
                if (fb)
                begin
                    r = r ^ dlef_pkg::CRC_POLY;
                end
            end
            return r;
        endfunction

        function void push_byte(logic [7:0] b, dlef_pkg::status_t st);
            frame_byte_t fb;
            fb.out_byte = b;
            fb.status = st;
            fb.run_last = 1'b0;
            item_bytes.push_back(fb);
        endfunction

        // One output byte, with its stuffed twin if stuffing applies and it is a DLE.
        function void emit(logic [7:0] b, bit in_crc, bit stuff);
            if (overflowed)
            begin
                return;
            end
            if (sent >= max_length)
            begin
                push_byte(8'h00, dlef_pkg::ST_NO_ROOM);
                overflowed = 1'b1;
                return;
            end
            push_byte(b, dlef_pkg::ST_OK);
            sent++;
            if (in_crc)
            begin
                crc = crc_update(crc, b);
            end
            if (stuff && b == dlef_pkg::DLE)
            begin
                if (sent >= max_length)
                begin
                    push_byte(8'h00, dlef_pkg::ST_NO_ROOM_DLE);
                    overflowed = 1'b1;
                    return;
                end
                push_byte(dlef_pkg::DLE, dlef_pkg::ST_OK);
                sent++;
            end
        endfunction

        function void note_request(logic [7:0] data, logic first, logic last);
            item_count++;
            item_bytes.delete();
            overflowed = 1'b0;
            if (first)
            begin
                crc = 8'h00;
                sent = 8'h00;
                open_frame = 1'b1;
                dropping = 1'b0;
                emit(dlef_pkg::DLE, 1'b0, 1'b0);
                emit(dlef_pkg::STX, 1'b0, 1'b0);
                emit(packet_type, 1'b1, 1'b1);
            end
            else if (!open_frame || dropping)
            begin
                return;
            end
            emit(data, 1'b1, 1'b1);
            if (last)
            begin
                emit(crc, 1'b0, 1'b1);
                emit(dlef_pkg::DLE, 1'b0, 1'b0);
                emit(dlef_pkg::ETX, 1'b0, 1'b0);
                open_frame = 1'b0;
            end
            if (overflowed)
            begin
                open_frame = 1'b0;
                dropping = 1'b1;
            end
            if (item_bytes.size() > 0)
            begin
                item_bytes[item_bytes.size() - 1].run_last = 1'b1;
            end
            foreach (item_bytes[i])
            begin
                pending.push_back(item_bytes[i]);
            end
        endfunction

        function void check_byte(logic [7:0] b, logic [1:0] st, logic last);
            frame_byte_t exp_byte;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte %02h status %0d last %0b",
                         $time, b, st, last);
                return;
            end
            exp_byte = pending.pop_front();
            if (b !== exp_byte.out_byte)
            begin
                errors++;
                $display("%0t: out_byte expected %02h actual %02h", $time,
                         exp_byte.out_byte, b);
            end
            if (st !== exp_byte.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_byte.status, st);
            end
            if (last !== exp_byte.run_last)
            begin
                errors++;
                $display("%0t: run_last expected %0b actual %0b", $time,
                         exp_byte.run_last, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_count = 0;
    int unsigned cycle_count = 0;

    frame_scoreboard sb = new();

    dlef_in_if  payload_ch ();
    dlef_out_if frame_ch ();

    dle_framer_with_crc8 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (payload_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Requests are noted before results are checked in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (payload_ch.valid && payload_ch.ready)
            begin
                sb.note_request(payload_ch.data_byte, payload_ch.first_byte,
                                payload_ch.final_byte);
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                sb.check_byte(frame_ch.out_byte, frame_ch.status, frame_ch.run_last);
            end
        end
    end

    // Output side: random stalls, plus one long hold-off to back up the input
    initial
    begin
        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                frame_ch.ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES)
                begin
                    hold_done = 1'b1;
                end
            end
            else
            begin
                frame_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1: return dlef_pkg::DLE;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic offer(input logic [7:0] data, input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            payload_ch.valid <= 1'b0;
            @(posedge clk);
        end
        payload_ch.valid <= 1'b1;
        payload_ch.data_byte <= data;
        payload_ch.first_byte <= first;
        payload_ch.final_byte <= last;
        @(posedge clk);
        while (!payload_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and let the block drain; bytes with no output may still be in flight.
    task automatic quiesce();
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dlef_pkg::cfg_index_t idx, input logic [7:0] value);
        quiesce();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames; some stray bytes, restarts and unterminated frames.
    task automatic send_frame();
        int len;
        bit abandon;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        abandon = ($urandom_range(99) < 8);
        if ($urandom_range(9) == 0)
        begin
            offer(pick_byte(), 1'b0, 1'($urandom_range(1)));
        end
        for (int i = 0; i < len; i++)
        begin
            offer(pick_byte(), (i == 0) || ($urandom_range(99) < 3),
                  (i == len - 1) && !abandon);
        end
    endtask

    initial
    begin
        logic [7:0]  seg_max [8];
        logic [7:0]  seg_type [8];
        int          send_pct [4];
        int          recv_pct [4];
        int unsigned target;

        seg_max = '{8'd255, 8'd40, 8'd255, 8'd12, 8'd255, 8'd1, 8'd60, 8'd255};
        seg_type = '{8'h00, 8'h10, 8'hFF, 8'h10, 8'h5C, 8'h00, 8'h00, 8'h00};
        send_pct = '{0, 55, 0, 31};
        recv_pct = '{0, 0, 55, 31};

        payload_ch.valid <= 1'b0;
        payload_ch.data_byte <= 8'h00;
        payload_ch.first_byte <= 1'b0;
        payload_ch.final_byte <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= dlef_pkg::CFG_MAX_LENGTH;
        cfg_wdata <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray byte, one-byte frames, restart inside a frame
        offer(8'h5A, 1'b0, 1'b0);
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hB3, 1'b1, 1'b1);        // CRC of type 00 then B3 is DLE
        offer(8'h10, 1'b1, 1'b0);
        offer(8'hFF, 1'b0, 1'b0);
        offer(8'h7E, 1'b1, 1'b0);
        offer(8'h10, 1'b0, 1'b1);
        offer(8'h33, 1'b0, 1'b1);
        write_reg(dlef_pkg::CFG_PACKET_TYPE, dlef_pkg::DLE);
        offer(8'hFF, 1'b1, 1'b1);
        // limit lowered with a frame open: the stuffed DLE finds no room
        write_reg(dlef_pkg::CFG_PACKET_TYPE, 8'hFF);
        offer(8'h01, 1'b1, 1'b0);
        write_reg(dlef_pkg::CFG_MAX_LENGTH, 8'd5);
        offer(8'h10, 1'b0, 1'b0);
        offer(8'h22, 1'b0, 1'b1);
        write_reg(dlef_pkg::CFG_MAX_LENGTH, 8'd0);
        offer(8'h80, 1'b1, 1'b1);
        offer(8'h01, 1'b0, 1'b1);
        write_reg(dlef_pkg::CFG_MAX_LENGTH, 8'd3);
        write_reg(dlef_pkg::CFG_PACKET_TYPE, dlef_pkg::DLE);
        offer(8'h00, 1'b1, 1'b0);
        write_reg(dlef_pkg::CFG_MAX_LENGTH, 8'd4);
        write_reg(dlef_pkg::CFG_PACKET_TYPE, 8'h00);
        offer(8'h55, 1'b1, 1'b1);
        write_reg(dlef_pkg::CFG_MAX_LENGTH, 8'd8);  // exact fit, ETX is byte 8
        offer(8'h10, 1'b1, 1'b1);

        for (int seg = 0; seg < 8; seg++)
        begin
            write_reg(dlef_pkg::CFG_MAX_LENGTH, seg_max[seg]);
            write_reg(dlef_pkg::CFG_PACKET_TYPE, (seg >= 5) ? pick_byte() : seg_type[seg]);
            send_idle_pct = send_pct[seg % 4];
            stall_pct = recv_pct[seg % 4];
            if (seg == 0)
            begin
                hold_request = 1'b1;
            end
            target = sb.item_count + SEG_ITEMS;
            while (sb.item_count < target)
            begin
                send_frame();
            end
        end

        quiesce();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
